[rtl/lru_cache_miss_counter_unit_macros.svh]
// ---------------------------------------------------------------------------
// assertion macros for the lru cache miss counter
// ---------------------------------------------------------------------------
`ifndef LRU_CACHE_MISS_COUNTER_UNIT_MACROS_SVH
`define LRU_CACHE_MISS_COUNTER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while reset is active
`define LCMC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcmc assertion failed");

// next-cycle implication
`define LCMC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcmc assertion failed");

`endif

[rtl/lcmc_pkg.sv]
// ---------------------------------------------------------------------------
// lcmc_pkg
// field widths, reset values and shared types for the lru miss counter
// ---------------------------------------------------------------------------
package lcmc_pkg;

  localparam int SIZE_W = 7;
  localparam int IDX_W  = 10;
  localparam int MISS_W = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  typedef logic [MISS_W-1:0] miss_cnt_t;
  typedef logic [IDX_W-1:0]  idx_field_t;
  typedef logic [SIZE_W-1:0] size_t;

  localparam miss_cnt_t MISS_MAX = '1;

endpackage

[rtl/lru_cache_miss_counter_unit.sv]
// pipeline: a beat accepted into the input register is presented on out_* from the result register
// throughput: one reference per cycle while the result side does not stall, set by the parallel tag
//   compare and recency shift across all CAPACITY slots between the input and result registers
// reset: cache empty, miss count zero, cache size 64, both stages empty
// ---------------------------------------------------------------------------
// lru_cache_miss_counter_unit
// fully associative lru cache tag store that counts misses per reference
// ---------------------------------------------------------------------------
module lru_cache_miss_counter_unit #(
  parameter int CAPACITY   = 64,
  parameter int INDEX_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_matrix_sel,
  input  lcmc_pkg::idx_field_t in_row_index,
  input  lcmc_pkg::idx_field_t in_col_index,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_hit,
  output lcmc_pkg::miss_cnt_t  out_miss_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  lcmc_pkg::size_t      cfg_data
);

  import lcmc_pkg::*;

  localparam int KEY_W = 2 * INDEX_BITS + 1;
  localparam int OCC_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (OCC_W > SIZE_W) ? OCC_W : SIZE_W;

  logic [INDEX_BITS-1:0] row_k;
  logic [INDEX_BITS-1:0] col_k;
  logic [KEY_W-1:0]      in_key;

  logic                  in_acc;
  logic                  adv;

  size_t                 size_r;
  logic                  s1_valid_r, s1_valid_nxt;
  logic [KEY_W-1:0]      s1_key_r;
  logic [KEY_W-1:0]      key_r   [CAPACITY];
  logic [KEY_W-1:0]      key_nxt [CAPACITY];
  logic [KEY_W-1:0]      nbr     [CAPACITY];
  logic [OCC_W-1:0]      occ_r, occ_nxt;
  miss_cnt_t             miss_r, miss_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_hit_r;
  miss_cnt_t             out_miss_r;

  logic [CAPACITY-1:0]   match;
  logic [CAPACITY-1:0]   at_or_after;
  logic                  hit;
  logic [CMP_W-1:0]      size_ext, eff_size;
  logic                  evict, do_shift, append;

  // low INDEX_BITS of each index field form the key, zero-extended if INDEX_BITS exceeds the field width
  if (INDEX_BITS <= IDX_W) begin : g_idx_trunc
    assign row_k = in_row_index[INDEX_BITS-1:0];
    assign col_k = in_col_index[INDEX_BITS-1:0];
  end else begin : g_idx_ext
    assign row_k = {{(INDEX_BITS-IDX_W){1'b0}}, in_row_index};
    assign col_k = {{(INDEX_BITS-IDX_W){1'b0}}, in_col_index};
  end

  assign in_key    = {in_matrix_sel, row_k, col_k};
  assign adv       = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !adv;
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // parallel tag compare over resident slots, slot 0 oldest
  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    assign match[i] = (OCC_W'(i) < occ_r) && (key_r[i] == s1_key_r);
    if (i == 0) begin : g_first
      assign at_or_after[i] = match[i];
    end else begin : g_rest
      assign at_or_after[i] = at_or_after[i-1] | match[i];
    end
    if (i < CAPACITY - 1) begin : g_nbr
      assign nbr[i] = key_r[i+1];
    end else begin : g_last
      assign nbr[i] = key_r[i];
    end
  end

  assign hit      = |match;
  assign size_ext = CMP_W'(size_r);
  assign eff_size = (size_ext > CMP_W'(CAPACITY)) ? CMP_W'(CAPACITY) : size_ext;
  assign evict    = !hit && (CMP_W'(occ_r) >= eff_size);
  // a miss with an empty cache and zero size keeps nothing
  assign do_shift = hit || (evict && (occ_r != '0));
  assign append   = !hit && !evict;

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      key_nxt[i] = key_r[i];
      if (adv) begin
        if (do_shift && (!hit || at_or_after[i]) && (OCC_W'(i + 1) < occ_r)) begin
          key_nxt[i] = nbr[i];
        end else if (do_shift && (OCC_W'(i + 1) == occ_r)) begin
          key_nxt[i] = s1_key_r;
        end else if (append && (OCC_W'(i) == occ_r)) begin
          key_nxt[i] = s1_key_r;
        end
      end
    end
  end

  always_comb begin
    occ_nxt = occ_r;
    if (adv && append) begin
      occ_nxt = occ_r + 1'b1;
    end
  end

  always_comb begin
    miss_nxt = miss_r;
    if (adv && !hit && (miss_r != MISS_MAX)) begin
      miss_nxt = miss_r + 1'b1;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= SIZE_RESET;
      s1_valid_r  <= 1'b0;
      occ_r       <= '0;
      miss_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        size_r <= cfg_data;
      end
      s1_valid_r  <= s1_valid_nxt;
      occ_r       <= occ_nxt;
      miss_r      <= miss_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_key_r <= in_key;
    end
    if (adv) begin
      out_hit_r  <= hit;
      out_miss_r <= miss_nxt;
    end
    key_r <= key_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_miss_count = out_miss_r;

endmodule

[rtl/lcmc_checker.sv]
// ---------------------------------------------------------------------------
// lcmc_checker
// port-level checks on the result channel of the lru miss counter
// ---------------------------------------------------------------------------
`include "lru_cache_miss_counter_unit_macros.svh"

module lcmc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input logic                out_hit,
  input lcmc_pkg::miss_cnt_t out_miss_count
);

  import lcmc_pkg::*;

  // a stalled result beat holds
  `LCMC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_hit) && $stable(out_miss_count))

  // a hit right after a taken beat leaves the count alone
  `LCMC_ASSERT_NOW(a_hit_keeps_count, $past(out_valid && !out_stall) && out_valid && out_hit, out_miss_count == $past(out_miss_count))

  // a miss right after a taken beat adds one, or stays saturated
  `LCMC_ASSERT_NOW(a_miss_adds_one, $past(out_valid && !out_stall) && out_valid && !out_hit, (out_miss_count == $past(out_miss_count) + 1'b1) || ($past(out_miss_count) == MISS_MAX && out_miss_count == MISS_MAX))

  // a miss count of zero can only come with a hit
  `LCMC_ASSERT_NOW(a_zero_is_hit, out_valid && (out_miss_count == '0), out_hit)

endmodule

bind lru_cache_miss_counter_unit lcmc_checker u_lcmc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_hit        (out_hit),
  .out_miss_count (out_miss_count)
);

[sim/tb_lru_cache_miss_counter_unit.sv]
// ---------------------------------------------------------------------------
// tb_lru_cache_miss_counter_unit
// drives cache references through the lru miss counter with random idle and
// stall on both channels, tracks resident keys in recency order alongside
// the block and checks hit flag and miss count of every result beat
// ---------------------------------------------------------------------------
module tb_lru_cache_miss_counter_unit;
  import lcmc_pkg::*;

  localparam int CACHE_SLOTS    = 64;
  localparam int IDLE_PCT       = 29;
  localparam int HOLD_CYCLES    = 64;
  localparam int SETTLE_CYCLES  = 4;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef logic [2*IDX_W:0] ref_key_t;
  typedef struct packed {
    logic      hit;
    miss_cnt_t miss_count;
  } lookup_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_matrix_sel = 1'b0;
  idx_field_t in_row_index = '0;
  idx_field_t in_col_index = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_hit;
  miss_cnt_t  out_miss_count;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  size_t      cfg_data = '0;

  // mirror of the tag store, oldest key first
  ref_key_t   lru_keys[$];
  size_t      cache_size_q = SIZE_RESET;
  miss_cnt_t  miss_total_q = '0;
  lookup_t    expected_lookups[$];
  lookup_t    head_lookup;

  int         errors = 0;
  int         quiet_cycles = 0;
  logic       sender_idle_en = 1'b1;
  logic       receiver_idle_en = 1'b1;
  logic       hold_req = 1'b0;

  lru_cache_miss_counter_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_matrix_sel  (in_matrix_sel),
    .in_row_index   (in_row_index),
    .in_col_index   (in_col_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_miss_count (out_miss_count),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic lookup_t predict_lookup(input ref_key_t key);
    lookup_t     r;
    int unsigned eff;
    int          found_at;
    eff = (cache_size_q > CACHE_SLOTS) ? CACHE_SLOTS : cache_size_q;
    found_at = -1;
    foreach (lru_keys[i]) begin
      if (found_at < 0 && lru_keys[i] == key) found_at = i;
    end
    r.hit = (found_at >= 0);
    if (r.hit) begin
      lru_keys.delete(found_at);
      lru_keys = {lru_keys, key};
    end else begin
      if (miss_total_q != MISS_MAX) miss_total_q++;
      if (lru_keys.size() + 1 > eff) begin
        // full: drop the oldest; with nothing resident the key is dropped at once
        if (lru_keys.size() > 0) begin
          void'(lru_keys.pop_front());
          lru_keys = {lru_keys, key};
        end
      end else begin
        lru_keys = {lru_keys, key};
      end
    end
    r.miss_count = miss_total_q;
    return r;
  endfunction

  // results are checked before the same edge's input beat is predicted
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_lookups.size() == 0) begin
          $error("result beat with no lookup pending");
          errors++;
        end else begin
          head_lookup = expected_lookups.pop_front();
          if (out_hit !== head_lookup.hit) begin
            $error("hit: expected %0d, got %0d", head_lookup.hit, out_hit);
            errors++;
          end
          if (out_miss_count !== head_lookup.miss_count) begin
            $error("miss_count: expected %0d, got %0d", head_lookup.miss_count,
                   out_miss_count);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) cache_size_q = cfg_data;
      if (in_valid && !in_stall) begin
        expected_lookups = {expected_lookups,
          predict_lookup({in_matrix_sel, in_row_index, in_col_index})};
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // result side: random stall, or a long hold when asked
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall <= receiver_idle_en && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  task automatic send_ref(input ref_key_t key);
    @(negedge clk);
    while (sender_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    {in_matrix_sel, in_row_index, in_col_index} <= key;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_cache_size(input size_t size_val);
    wait_for_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= size_val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // default size after reset, field extremes, matrix select alone telling keys apart
  task automatic test_reset_size();
    send_ref({1'b0, 10'd0, 10'd0});
    send_ref({1'b1, 10'd1023, 10'd1023});
    send_ref({1'b0, 10'd0, 10'd0});
    send_ref({1'b1, 10'd0, 10'd0});
    send_ref({1'b0, 10'd1023, 10'd0});
    send_ref({1'b0, 10'd0, 10'd1023});
    send_ref({1'b1, 10'd1023, 10'd1023});
  endtask

  // nothing is kept, repeated key still misses
  task automatic test_zero_size();
    set_cache_size(7'd0);
    repeat (3) send_ref({1'b1, 10'h2aa, 10'h155});
  endtask

  task automatic test_single_entry();
    set_cache_size(7'd1);
    send_ref({1'b0, 10'h155, 10'h2aa});
    send_ref({1'b0, 10'h155, 10'h2aa});
    send_ref({1'b1, 10'h155, 10'h2aa});
    send_ref({1'b0, 10'h155, 10'h2aa});
  endtask

  // sizes above the slot count act as the slot count
  task automatic test_oversize();
    set_cache_size(7'd127);
    send_ref({1'b0, 10'h155, 10'h2aa});
    send_ref({1'b0, 10'd7, 10'd9});
    send_ref({1'b0, 10'h155, 10'h2aa});
  endtask

  // after shrinking, misses swap one key for one and hits evict nothing
  task automatic test_shrink_while_full();
    set_cache_size(7'd4);
    send_ref({1'b0, 10'd1, 10'd1});
    send_ref({1'b0, 10'd2, 10'd2});
    send_ref({1'b1, 10'd3, 10'd3});
    send_ref({1'b1, 10'd4, 10'd4});
    set_cache_size(7'd2);
    send_ref({1'b1, 10'd4, 10'd4});
    send_ref({1'b0, 10'd5, 10'd5});
    send_ref({1'b1, 10'd3, 10'd3});
  endtask

  task automatic send_pool_refs(input int unsigned pool_n, input int unsigned beats);
    ref_key_t key_pool[$];
    repeat (pool_n) key_pool = {key_pool, ref_key_t'($urandom)};
    repeat (beats) begin
      if ($urandom_range(9) == 0) send_ref(ref_key_t'($urandom));
      else send_ref(key_pool[$urandom_range(pool_n - 1)]);
    end
  endtask

  // result side holds off long enough that the block fills and stalls its input
  task automatic test_receiver_hold();
    set_cache_size(7'd16);
    hold_req = 1'b1;
    send_pool_refs(20, 40);
  endtask

  task automatic test_sender_pause();
    send_pool_refs(12, 20);
    wait_for_results();
    send_pool_refs(12, 20);
  endtask

  task automatic test_random_sizes();
    size_t       sizes[13];
    int unsigned eff;
    sizes = '{7'd64, 7'd127, 7'd0, 7'd1, 7'd2, 7'd5, 7'd16, 7'd33, 7'd65, 7'd100,
              7'd8, 7'd63, 7'd64};
    foreach (sizes[p]) begin
      set_cache_size(sizes[p]);
      eff = (sizes[p] > CACHE_SLOTS) ? CACHE_SLOTS : sizes[p];
      // one phase runs back to back on both sides
      sender_idle_en   = (p != 6);
      receiver_idle_en = (p != 6);
      send_pool_refs((eff == 0) ? 4 : $urandom_range(eff / 2 + 1, eff + eff / 2 + 2), 80);
    end
    sender_idle_en   = 1'b1;
    receiver_idle_en = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_size();
    test_zero_size();
    test_single_entry();
    test_oversize();
    test_shrink_while_full();
    test_receiver_hold();
    test_sender_pause();
    test_random_sizes();
    wait_for_results();
    if (errors == 0 && expected_lookups.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
